// ===== design/bcpu_pkg.sv =====
// Shared definitions for the byte CPU execute unit: operation codes, flag
// bit positions, reset values and the result record type.
// No dependencies.
`default_nettype none

package bcpu_pkg;

    localparam int OP_W   = 5;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_LDA = 5'd0;
    localparam logic [OP_W-1:0] OP_LDX = 5'd1;
    localparam logic [OP_W-1:0] OP_LDY = 5'd2;
    localparam logic [OP_W-1:0] OP_STA = 5'd3;
    localparam logic [OP_W-1:0] OP_STX = 5'd4;
    localparam logic [OP_W-1:0] OP_STY = 5'd5;
    localparam logic [OP_W-1:0] OP_TAX = 5'd6;
    localparam logic [OP_W-1:0] OP_TAY = 5'd7;
    localparam logic [OP_W-1:0] OP_TXA = 5'd8;
    localparam logic [OP_W-1:0] OP_TYA = 5'd9;
    localparam logic [OP_W-1:0] OP_TSX = 5'd10;
    localparam logic [OP_W-1:0] OP_TXS = 5'd11;
    localparam logic [OP_W-1:0] OP_PHA = 5'd12;
    localparam logic [OP_W-1:0] OP_PHP = 5'd13;
    localparam logic [OP_W-1:0] OP_PLA = 5'd14;
    localparam logic [OP_W-1:0] OP_PLP = 5'd15;
    localparam logic [OP_W-1:0] OP_AND = 5'd16;
    localparam logic [OP_W-1:0] OP_ORA = 5'd17;
    localparam logic [OP_W-1:0] OP_EOR = 5'd18;
    localparam logic [OP_W-1:0] OP_BIT = 5'd19;
    localparam logic [OP_W-1:0] OP_ADC = 5'd20;
    localparam logic [OP_W-1:0] OP_SBC = 5'd21;
    localparam logic [OP_W-1:0] OP_CMP = 5'd22;
    localparam logic [OP_W-1:0] OP_CPX = 5'd23;
    localparam logic [OP_W-1:0] OP_CPY = 5'd24;
    localparam logic [OP_W-1:0] OP_INC = 5'd25;
    localparam logic [OP_W-1:0] OP_INX = 5'd26;
    localparam logic [OP_W-1:0] OP_INY = 5'd27;
    localparam logic [OP_W-1:0] OP_DEC = 5'd28;
    localparam logic [OP_W-1:0] OP_DEX = 5'd29;
    localparam logic [OP_W-1:0] OP_DEY = 5'd30;

    // status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [BYTE_W-1:0] SP_RESET     = 8'hFD;
    localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h24;
    localparam logic [BYTE_W-1:0] PUSH_P_MASK  = 8'h30;   // B and U
    localparam logic [BYTE_W-1:0] PULL_P_MASK  = 8'h20;   // U

    // BCD correction constants
    localparam logic [5:0] BCD_LO_FIX   = 6'h06;
    localparam logic [4:0] BCD_LO_MAX   = 5'h09;
    localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
    localparam logic [9:0] BCD_HI_FIX   = 10'h060;
    localparam logic [9:0] BCD_BYTE_MAX = 10'h099;

    typedef struct packed {
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        logic [ADDR_W-1:0] stack_address;
        logic [BYTE_W-1:0] store_data;
        logic              store_valid;
    } t_result;

endpackage

`default_nettype wire

// ===== design/byte_cpu_execute_unit.sv =====
// Byte CPU execute unit: 8-bit register file, flags and ALU with BCD mode.
// Depends on bcpu_pkg.
`default_nettype none

//  channel   | dir | handshake                   | payload
//  s_axis    | in  | tvalid/tready               | tdata: op, operand
//  m_axis    | out | tvalid/tready               | tdata: registers; tuser: store_valid
//
//  One operation per clock unless the output stalls: the ALU result and the
//  register update are computed in the cycle of the input transfer and land
//  in the output register and the architectural registers at that edge.
//  Output valid rises in the cycle after the input transfer.
//  i_rst_n (sync, active low) sets A=X=Y=0, S=0xFD, P=0x24 and empties the output.
//  Input is taken whenever the output register is empty or being drained.
module byte_cpu_execute_unit
    import bcpu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [4:0] op, [12:5] operand
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] store_data, [16:8] stack_address, [24:17] accumulator_out,
    // [32:25] index_x_out, [40:33] index_y_out, [48:41] stack_pointer_out,
    // [56:49] status_out
    output      logic [63:0] o_m_axis_tdata,
    output      logic        o_m_axis_tuser    // [0] store_valid
);

    logic [BYTE_W-1:0] r_acc, r_x, r_y, r_sp, r_p;
    logic [BYTE_W-1:0] n_acc, n_x, n_y, n_sp, n_p;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] m;
    logic              accept;
    logic              cin;

    // binary add / subtract
    logic [BYTE_W:0]   bin_add, bin_sub;
    logic [BYTE_W-1:0] m_inv;
    // decimal add
    logic [4:0]        dadd_lo;
    logic [5:0]        dadd_lo_adj;
    logic [8:0]        dadd_s;
    logic [9:0]        dadd_fix;
    // decimal subtract
    logic [9:0]        dsub_lo, dsub_hi, dsub_d, dsub_fix;
    // compare
    logic [BYTE_W-1:0] cmp_reg, cmp_diff;
    logic [BYTE_W-1:0] nz_val;
    logic              nz_upd;

    assign op     = i_s_axis_tdata[OP_W-1:0];
    assign m      = i_s_axis_tdata[OP_W +: BYTE_W];
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign cin    = r_p[FLAG_C];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;

    always_comb begin
        m_inv   = ~m;
        bin_add = {1'b0, r_acc} + {1'b0, m} + {{BYTE_W{1'b0}}, cin};
        bin_sub = {1'b0, r_acc} + {1'b0, m_inv} + {{BYTE_W{1'b0}}, cin};

        dadd_lo     = {1'b0, r_acc[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
        dadd_lo_adj = (dadd_lo > BCD_LO_MAX) ? ({1'b0, dadd_lo} + BCD_LO_FIX)
                                             : {1'b0, dadd_lo};
        dadd_s      = {1'b0, r_acc[7:4], 4'd0} + {1'b0, m[7:4], 4'd0}
                    + ((dadd_lo_adj > 6'd15) ? 9'h010 : 9'h000)
                    + {5'd0, dadd_lo_adj[3:0]};
        dadd_fix    = (dadd_s[7:4] > BCD_DIGIT_MAX) ? ({1'b0, dadd_s} + BCD_HI_FIX)
                                                    : {1'b0, dadd_s};

        // 10-bit wrap keeps bit 8 exact for the borrow logic
        dsub_lo = {6'd0, r_acc[3:0]} - {6'd0, m[3:0]} - {9'd0, ~cin};
        if (dsub_lo[4]) begin
            dsub_hi = {2'd0, r_acc[7:4], 4'd0} - {2'd0, m[7:4], 4'd0} - 10'h010;
            dsub_d  = dsub_hi | {6'd0, dsub_lo[3:0] - BCD_LO_FIX[3:0]};
        end else begin
            dsub_hi = {2'd0, r_acc[7:4], 4'd0} - {2'd0, m[7:4], 4'd0};
            dsub_d  = dsub_hi | {6'd0, dsub_lo[3:0]};
        end
        dsub_fix = dsub_d[8] ? (dsub_d - BCD_HI_FIX) : dsub_d;

        unique case (op)
            OP_CPX:  cmp_reg = r_x;
            OP_CPY:  cmp_reg = r_y;
            default: cmp_reg = r_acc;
        endcase
        cmp_diff = cmp_reg - m;
    end

    always_comb begin
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_sp   = r_sp;
        n_p    = r_p;
        n_out  = '0;
        nz_val = '0;
        nz_upd = 1'b0;

        unique case (op)
            OP_LDA: begin n_acc = m; nz_val = m; nz_upd = 1'b1; end
            OP_LDX: begin n_x = m; nz_val = m; nz_upd = 1'b1; end
            OP_LDY: begin n_y = m; nz_val = m; nz_upd = 1'b1; end
            OP_STA: begin n_out.store_data = r_acc; n_out.store_valid = 1'b1; end
            OP_STX: begin n_out.store_data = r_x; n_out.store_valid = 1'b1; end
            OP_STY: begin n_out.store_data = r_y; n_out.store_valid = 1'b1; end
            OP_TAX: begin n_x = r_acc; nz_val = r_acc; nz_upd = 1'b1; end
            OP_TAY: begin n_y = r_acc; nz_val = r_acc; nz_upd = 1'b1; end
            OP_TXA: begin n_acc = r_x; nz_val = r_x; nz_upd = 1'b1; end
            OP_TYA: begin n_acc = r_y; nz_val = r_y; nz_upd = 1'b1; end
            OP_TSX: begin n_x = r_sp; nz_val = r_sp; nz_upd = 1'b1; end
            OP_TXS: begin n_sp = r_x; end
            OP_PHA: begin
                n_out.store_data  = r_acc;
                n_out.store_valid = 1'b1;
                n_sp              = r_sp - 8'd1;
            end
            OP_PHP: begin
                n_out.store_data  = r_p | PUSH_P_MASK;
                n_out.store_valid = 1'b1;
                n_sp              = r_sp - 8'd1;
            end
            OP_PLA: begin
                n_sp = r_sp + 8'd1; n_acc = m; nz_val = m; nz_upd = 1'b1;
            end
            OP_PLP: begin n_sp = r_sp + 8'd1; n_p = m | PULL_P_MASK; end
            OP_AND: begin n_acc = r_acc & m; nz_val = r_acc & m; nz_upd = 1'b1; end
            OP_ORA: begin n_acc = r_acc | m; nz_val = r_acc | m; nz_upd = 1'b1; end
            OP_EOR: begin n_acc = r_acc ^ m; nz_val = r_acc ^ m; nz_upd = 1'b1; end
            OP_BIT: begin
                n_p[FLAG_Z] = ((r_acc & m) == 8'd0);
                n_p[FLAG_N] = m[7];
                n_p[FLAG_V] = m[6];
            end
            OP_ADC: begin
                if (r_p[FLAG_D]) begin
                    // N, Z, V come from the sum before the high digit fix
                    n_p[FLAG_N] = dadd_s[7];
                    n_p[FLAG_Z] = (dadd_s[7:0] == 8'd0);
                    n_p[FLAG_V] = (r_acc[7] ^ dadd_s[7]) & (m[7] ^ dadd_s[7]);
                    n_p[FLAG_C] = (dadd_fix > BCD_BYTE_MAX);
                    n_acc       = dadd_fix[7:0];
                end else begin
                    n_p[FLAG_C] = bin_add[8];
                    n_p[FLAG_V] = (r_acc[7] ^ bin_add[7]) & (m[7] ^ bin_add[7]);
                    n_acc       = bin_add[7:0];
                    nz_val      = bin_add[7:0];
                    nz_upd      = 1'b1;
                end
            end
            OP_SBC: begin
                if (r_p[FLAG_D]) begin
                    n_p[FLAG_C] = !dsub_fix[8];
                    n_acc       = dsub_fix[7:0];
                    nz_val      = dsub_fix[7:0];
                end else begin
                    n_p[FLAG_C] = bin_sub[8];
                    n_p[FLAG_V] = (r_acc[7] ^ bin_sub[7]) & (m_inv[7] ^ bin_sub[7]);
                    n_acc       = bin_sub[7:0];
                    nz_val      = bin_sub[7:0];
                end
                nz_upd = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                n_p[FLAG_C] = (cmp_reg >= m);
                n_p[FLAG_Z] = (cmp_reg == m);
                n_p[FLAG_N] = cmp_diff[7];
            end
            OP_INC: begin
                n_out.store_data  = m + 8'd1;
                n_out.store_valid = 1'b1;
                nz_val = m + 8'd1; nz_upd = 1'b1;
            end
            OP_INX: begin n_x = r_x + 8'd1; nz_val = r_x + 8'd1; nz_upd = 1'b1; end
            OP_INY: begin n_y = r_y + 8'd1; nz_val = r_y + 8'd1; nz_upd = 1'b1; end
            OP_DEC: begin
                n_out.store_data  = m - 8'd1;
                n_out.store_valid = 1'b1;
                nz_val = m - 8'd1; nz_upd = 1'b1;
            end
            OP_DEX: begin n_x = r_x - 8'd1; nz_val = r_x - 8'd1; nz_upd = 1'b1; end
            OP_DEY: begin n_y = r_y - 8'd1; nz_val = r_y - 8'd1; nz_upd = 1'b1; end
            default: ;   // unused code: no change
        endcase

        if (nz_upd) begin
            n_p[FLAG_Z] = (nz_val == 8'd0);
            n_p[FLAG_N] = nz_val[7];
        end

        // pushes report the pointer before the decrement, all others the updated pointer
        if (op == OP_PHA || op == OP_PHP) begin
            n_out.stack_address = {1'b1, r_sp};
        end else begin
            n_out.stack_address = {1'b1, n_sp};
        end
        n_out.acc    = n_acc;
        n_out.x      = n_x;
        n_out.y      = n_y;
        n_out.sp     = n_sp;
        n_out.status = n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_sp        <= SP_RESET;
            r_p         <= STATUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_acc <= n_acc;
                r_x   <= n_x;
                r_y   <= n_y;
                r_sp  <= n_sp;
                r_p   <= n_p;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.store_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.status, r_out.sp, r_out.y, r_out.x,
                              r_out.acc, r_out.stack_address, r_out.store_data};

endmodule

`default_nettype wire

// ===== design/bcpu_checker.sv =====
// Port-level checks for the byte CPU execute unit, bound to the top level.
// Depends on byte_cpu_execute_unit (bind target) only.
`default_nettype none

module bcpu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [15:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    // input side opens exactly when the output register can take a result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output state");

    // every input transfer yields a result on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("no result after input transfer");

    // U flag is always set in reported status
    a_u_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[54])
        else $error("status U flag clear");

    // stack address lies in page one; with no store, the store byte is zero
    a_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[16] && (o_m_axis_tuser || o_m_axis_tdata[7:0] == 8'd0))
        else $error("store byte without store strobe");

endmodule

bind byte_cpu_execute_unit bcpu_checker u_bcpu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
